>>> rtl/ibs_pkg.sv
// shared constants, register codes and stage types for the box subsampler
package ibs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_FACTOR = 16;

	localparam int PIX_W  = 8;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CFG_W  = 11;
	localparam int FAC_W  = 5;
	localparam int BLK_W  = $clog2(MAX_FACTOR);
	localparam int SUM_W  = 16;
	localparam int AREA_W = 9;
	localparam int DIV_W  = AREA_W + 1;
	localparam int DVD_W  = SUM_W + 2;
	localparam int PROD_W = 16;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] CFG_IMAGE_ROWS   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_IMAGE_COLS   = 2'd1;
	localparam logic [IDX_W-1:0] CFG_BLOCK_FACTOR = 2'd2;

	typedef struct packed {
		logic              use_px;
		logic              first;
		logic              complete;
		logic              last;
		logic [ROW_W-1:0]  brow;
		logic [COL_W-1:0]  bcol;
		logic [AREA_W-1:0] area;
	} ibs_item_t;

	typedef struct packed {
		logic [DVD_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
		logic [ROW_W-1:0] brow;
		logic [COL_W-1:0] bcol;
		logic             last;
	} ibs_job_t;

endpackage

>>> rtl/image_box_subsample_core.sv
// top level of the box filter subsampler
// Grey pixels arrive in raster order, one per request, and the block takes one pixel per
// clock while no completed block waits for the divider. Each pixel updates a per-column
// sum in a 1024 x 16 memory by a read on accept and a write as it leaves the stage
// register, with forwarding between neighbouring pixels of the same block column. The
// bottom-right pixel of a complete block hands its sum to a shared serial divider, whose
// result goes to the output register; a block that completes while the divider is busy
// holds the input until it is free, so stalls come only in the last pixel row of each
// band of blocks. Partial blocks at the right and bottom edges give no result. Column
// sums need no clearing after reset: each is overwritten by the first pixel of its block.
// The user writes settings only while no work is in flight; the block does not enforce it.
module image_box_subsample_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [ibs_pkg::IDX_W-1:0] cfg_index,
	input  logic [ibs_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ibs_pkg::PIX_W-1:0] pixel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ibs_pkg::PIX_W-1:0] mean_value,
	output logic [ibs_pkg::ROW_W-1:0] out_row,
	output logic [ibs_pkg::COL_W-1:0] out_col,
	output logic                      last_of_image
);
	import ibs_pkg::*;

	ibs_item_t item;
	ibs_job_t  job;
	logic      job_valid, job_ready;

	ibs_position u_position (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_valid && in_ready),
		.item      (item)
	);

	ibs_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.item      (item),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	ibs_divider u_divider (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_ready     (job_ready),
		.job           (job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.mean_value    (mean_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.last_of_image (last_of_image)
	);

endmodule

>>> rtl/ibs_position.sv
// configuration registers and raster position counters
module ibs_position (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [ibs_pkg::IDX_W-1:0] cfg_index,
	input  logic [ibs_pkg::CFG_W-1:0] cfg_data,
	input  logic                      advance,
	output ibs_pkg::ibs_item_t        item
);
	import ibs_pkg::*;

	logic [CFG_W-1:0]  rows_q, cols_q;
	logic [FAC_W-1:0]  fac_q;
	logic [CFG_W-1:0]  rows, cols;
	logic [FAC_W-1:0]  fac;

	logic [COL_W-1:0]  cp_q, bc_q;
	logic [ROW_W-1:0]  rp_q, br_q;
	logic [BLK_W-1:0]  cib_q, rib_q;

	logic [PROD_W-1:0] row_lo, row_hi, col_lo, col_hi;
	logic              row_ok, col_ok, row_end, col_end;

	logic [COL_W:0]    cp_n, bc_n;
	logic [ROW_W:0]    rp_n, br_n;
	logic [BLK_W:0]    cib_n, rib_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(1);
			cols_q <= CFG_W'(1);
			fac_q  <= FAC_W'(2);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IMAGE_ROWS:   rows_q <= cfg_data;
				CFG_IMAGE_COLS:   cols_q <= cfg_data;
				CFG_BLOCK_FACTOR: fac_q  <= cfg_data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range settings clamp to the supported range
	always_comb begin
		rows = rows_q;
		if (rows_q == '0)
			rows = CFG_W'(1);
		else if (rows_q > CFG_W'(MAX_HEIGHT))
			rows = CFG_W'(MAX_HEIGHT);
		cols = cols_q;
		if (cols_q == '0)
			cols = CFG_W'(1);
		else if (cols_q > CFG_W'(MAX_WIDTH))
			cols = CFG_W'(MAX_WIDTH);
		fac = fac_q;
		if (fac_q == '0)
			fac = FAC_W'(1);
		else if (fac_q > FAC_W'(MAX_FACTOR))
			fac = FAC_W'(MAX_FACTOR);
	end

	// block lies inside the image when its far edge is within the image
	always_comb begin
		row_lo  = (PROD_W'(br_q) + PROD_W'(1)) * PROD_W'(fac);
		row_hi  = (PROD_W'(br_q) + PROD_W'(2)) * PROD_W'(fac);
		col_lo  = (PROD_W'(bc_q) + PROD_W'(1)) * PROD_W'(fac);
		col_hi  = (PROD_W'(bc_q) + PROD_W'(2)) * PROD_W'(fac);
		row_ok  = row_lo <= PROD_W'(rows);
		col_ok  = col_lo <= PROD_W'(cols);
		row_end = row_hi > PROD_W'(rows);
		col_end = col_hi > PROD_W'(cols);
	end

	always_comb begin
		item.use_px   = row_ok && col_ok && (FAC_W'(rib_q) < fac) && (FAC_W'(cib_q) < fac);
		item.first    = (rib_q == '0) && (cib_q == '0);
		item.complete = (FAC_W'(rib_q) == fac - FAC_W'(1)) &&
		                (FAC_W'(cib_q) == fac - FAC_W'(1));
		item.last     = row_ok && col_ok && row_end && col_end;
		item.brow     = br_q;
		item.bcol     = bc_q;
		item.area     = AREA_W'(fac) * AREA_W'(fac);
	end

	always_comb begin
		cp_n  = {1'b0, cp_q} + (COL_W+1)'(1);
		cib_n = {1'b0, cib_q} + (BLK_W+1)'(1);
		bc_n  = (FAC_W'(cib_n) >= fac) ? {1'b0, bc_q} + (COL_W+1)'(1) : {1'b0, bc_q};
		rp_n  = {1'b0, rp_q} + (ROW_W+1)'(1);
		rib_n = {1'b0, rib_q} + (BLK_W+1)'(1);
		br_n  = (FAC_W'(rib_n) >= fac) ? {1'b0, br_q} + (ROW_W+1)'(1) : {1'b0, br_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q  <= '0;
			bc_q  <= '0;
			cib_q <= '0;
			rp_q  <= '0;
			br_q  <= '0;
			rib_q <= '0;
		end else if (advance) begin
			if (CFG_W'(cp_n) >= cols) begin
				cp_q  <= '0;
				bc_q  <= '0;
				cib_q <= '0;
				if (CFG_W'(rp_n) >= rows) begin
					rp_q  <= '0;
					br_q  <= '0;
					rib_q <= '0;
				end else begin
					rp_q  <= rp_n[ROW_W-1:0];
					br_q  <= br_n[ROW_W-1:0];
					rib_q <= (FAC_W'(rib_n) >= fac) ? '0 : rib_n[BLK_W-1:0];
				end
			end else begin
				cp_q  <= cp_n[COL_W-1:0];
				bc_q  <= bc_n[COL_W-1:0];
				cib_q <= (FAC_W'(cib_n) >= fac) ? '0 : cib_n[BLK_W-1:0];
			end
		end
	end

endmodule

>>> rtl/ibs_accum.sv
// column sum memory with read-modify-write and same-column forwarding
module ibs_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ibs_pkg::PIX_W-1:0] pixel,
	input  ibs_pkg::ibs_item_t        item,
	output logic                      job_valid,
	input  logic                      job_ready,
	output ibs_pkg::ibs_job_t         job
);
	import ibs_pkg::*;

	logic [SUM_W-1:0] sum_mem [MAX_WIDTH];
	logic [SUM_W-1:0] rd_data_q;

	logic             valid_s1;
	ibs_item_t        item_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             fwd_hit_q;
	logic [SUM_W-1:0] fwd_data_q;

	logic             in_fire, load, fire_s1;
	logic [SUM_W-1:0] base, sum_s1;

	assign fire_s1  = valid_s1 && (!item_s1.complete || job_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign in_fire  = in_valid && in_ready;
	assign load     = in_fire && item.use_px;

	assign base   = fwd_hit_q ? fwd_data_q : rd_data_q;
	assign sum_s1 = item_s1.first ? SUM_W'(pixel_s1) : base + SUM_W'(pixel_s1);

	always_ff @(posedge clk) begin
		if (valid_s1 && fire_s1)
			sum_mem[item_s1.bcol] <= sum_s1;
		if (load)
			rd_data_q <= sum_mem[item.bcol];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= load;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1    <= item;
			pixel_s1   <= pixel;
			fwd_hit_q  <= fire_s1 && (item_s1.bcol == item.bcol);
			fwd_data_q <= sum_s1;
		end
	end

	assign job_valid    = valid_s1 && item_s1.complete;
	assign job.dividend = {1'b0, sum_s1, 1'b0} + DVD_W'(item_s1.area);
	assign job.divisor  = {item_s1.area, 1'b0};
	assign job.brow     = item_s1.brow;
	assign job.bcol     = item_s1.bcol;
	assign job.last     = item_s1.last;

endmodule

>>> rtl/ibs_divider.sv
// serial restoring divider for the rounded mean and the output register
module ibs_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	output logic                      job_ready,
	input  ibs_pkg::ibs_job_t         job,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ibs_pkg::PIX_W-1:0] mean_value,
	output logic [ibs_pkg::ROW_W-1:0] out_row,
	output logic [ibs_pkg::COL_W-1:0] out_col,
	output logic                      last_of_image
);
	import ibs_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q, div_q;
	logic [DVD_W-1:0] quo_q;
	logic [ROW_W-1:0] brow_q;
	logic [COL_W-1:0] bcol_q;
	logic             last_q;
	logic             out_valid_q;

	logic [DIV_W:0]   trial, diff;
	logic             ge;
	logic [DIV_W-1:0] step_rem;
	logic             load_out;

	assign job_ready = (state_q == ST_IDLE);
	assign load_out  = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	always_comb begin
		trial    = {rem_q, quo_q[DVD_W-1]};
		diff     = trial - {1'b0, div_q};
		ge       = trial >= {1'b0, div_q};
		step_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(DVD_W - 1);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			rem_q  <= '0;
			quo_q  <= job.dividend;
			div_q  <= job.divisor;
			brow_q <= job.brow;
			bcol_q <= job.bcol;
			last_q <= job.last;
		end else if (state_q == ST_RUN) begin
			rem_q <= step_rem;
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
		if (load_out) begin
			mean_value    <= quo_q[PIX_W-1:0];
			out_row       <= brow_q;
			out_col       <= bcol_q;
			last_of_image <= last_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/ibs_checker.sv
// port-level checks for the box filter subsampler, bound to the top level
module ibs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [ibs_pkg::PIX_W-1:0] mean_value,
	input logic [ibs_pkg::ROW_W-1:0] out_row,
	input logic [ibs_pkg::COL_W-1:0] out_col,
	input logic                      last_of_image
);
	import ibs_pkg::*;

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= 1'b0;
		else if (in_valid && in_ready)
			seen_q <= 1'b1;
	end

	// stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_value) && $stable(out_row) &&
		$stable(out_col) && $stable(last_of_image))
		else $error("result changed while stalled");

	// result leaves only when taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

	// a result needs a request to have been accepted earlier
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(seen_q, 16))
		else $error("result too soon after first request");

	// input stalls only after a pixel has been accepted
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> seen_q)
		else $error("input stalled with nothing accepted");

endmodule

bind image_box_subsample_core ibs_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.mean_value    (mean_value),
	.out_row       (out_row),
	.out_col       (out_col),
	.last_of_image (last_of_image)
);
